// File: hw/rtl/nsalu_pkg.sv
// Package for the nibble ALU slice: opcodes and the result bundle.
package nsalu_pkg;

  localparam int unsigned NibW = 4;
  localparam int unsigned OpW  = 6;

  // Opcodes with the top bit set pass operand a through.
  localparam int unsigned OpPassBit = OpW - 1;

  typedef enum logic [OpW-1:0] {
    OP_SETIO = 6'd0,
    OP_INC   = 6'd1,
    OP_DEC   = 6'd2,
    OP_ADD   = 6'd3,
    OP_NOT   = 6'd4,
    OP_SHL   = 6'd5,
    OP_SHR   = 6'd6,
    OP_ROR   = 6'd7,
    OP_OR    = 6'd8,
    OP_AND   = 6'd9,
    OP_XOR   = 6'd10,
    OP_ADC   = 6'd11,
    OP_SUB   = 6'd12
  } opcode_t;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [NibW-1:0] operand_a;
    logic [NibW-1:0] operand_b;
    logic            carry_in_global;
    logic            high_slice;
    logic            peer_zero;
    logic            peer_carry;
  } operands_t;

  typedef struct packed {
    logic [NibW-1:0] result_nibble;
    logic            nib_zero;
    logic            nib_carry;
    logic            zero_flag;
    logic            io_enable_flag;
    logic            carry_flag;
    logic            overflow_flag;
  } result_t;

endpackage

// File: hw/rtl/nsalu_core.sv
// Combinational nibble ALU: operation decode, arithmetic and flag logic.
module nsalu_core (
  input  nsalu_pkg::operands_t opnd,
  output nsalu_pkg::result_t   res
);
  import nsalu_pkg::*;

  always_comb begin
    logic [NibW:0]   q;
    logic            hc;
    logic            cf;
    logic            ovf;
    logic            cin;
    logic            as;
    logic            bs;
    logic            hi;
    logic            use_flags;

    q         = '0;
    hc        = 1'b0;
    cf        = 1'b0;
    ovf       = 1'b0;
    use_flags = 1'b0;
    hi        = opnd.high_slice;
    as        = opnd.operand_a[NibW-1];
    bs        = opnd.operand_b[NibW-1];
    cin       = hi ? opnd.peer_carry : 1'b1;
    res       = '0;

    if (opnd.opcode[OpPassBit]) begin
      res.result_nibble = opnd.operand_a;
    end else begin
      unique case (opnd.opcode)
        OP_SETIO: begin
          res.io_enable_flag = !hi;
        end
        OP_INC: begin
          q         = {1'b0, opnd.operand_a} + {{NibW{1'b0}}, cin};
          hc        = q[NibW];
          cf        = opnd.carry_in_global;
          ovf       = !as && q[NibW-1];
          use_flags = 1'b1;
        end
        OP_DEC: begin
          q         = {1'b0, opnd.operand_a} - {{NibW{1'b0}}, cin};
          hc        = q[NibW];
          cf        = opnd.carry_in_global;
          ovf       = as && !q[NibW-1];
          use_flags = 1'b1;
        end
        OP_ADD, OP_ADC: begin
          // Chain the peer carry in the high slice; only adc takes stored carry low.
          cin = hi ? opnd.peer_carry
                   : ((opnd.opcode == OP_ADC) && opnd.carry_in_global);
          q   = {1'b0, opnd.operand_a} + {1'b0, opnd.operand_b}
                + {{NibW{1'b0}}, cin};
          hc  = q[NibW];
          cf  = q[NibW];
          ovf = (as == bs) && (q[NibW-1] != as);
          use_flags = 1'b1;
        end
        OP_NOT: begin
          q         = {1'b0, ~opnd.operand_a};
          hc        = 1'b1;
          use_flags = 1'b1;
        end
        OP_SHL: begin
          q         = {opnd.operand_a, hi && opnd.peer_carry};
          hc        = q[NibW];
          cf        = q[NibW];
          use_flags = 1'b1;
        end
        OP_SHR: begin
          q         = {1'b0, !hi && opnd.peer_carry, opnd.operand_a[NibW-1:1]};
          hc        = opnd.operand_a[0];
          cf        = opnd.peer_carry;
          use_flags = 1'b1;
        end
        OP_ROR: begin
          q         = {1'b0, opnd.peer_carry, opnd.operand_a[NibW-1:1]};
          hc        = opnd.operand_a[0];
          cf        = opnd.peer_carry;
          use_flags = 1'b1;
        end
        OP_OR: begin
          q         = {1'b0, opnd.operand_a | opnd.operand_b};
          use_flags = 1'b1;
        end
        OP_AND: begin
          q         = {1'b0, opnd.operand_a & opnd.operand_b};
          use_flags = 1'b1;
        end
        OP_XOR: begin
          q         = {1'b0, opnd.operand_a ^ opnd.operand_b};
          use_flags = 1'b1;
        end
        OP_SUB: begin
          q   = {1'b0, opnd.operand_a} - {1'b0, opnd.operand_b}
                - {{NibW{1'b0}}, hi && opnd.peer_carry};
          hc  = q[NibW];
          cf  = q[NibW];
          ovf = (as != bs) && (q[NibW-1] != as);
          use_flags = 1'b1;
        end
        default: begin
          // Unused opcodes give all zeros.
        end
      endcase

      if (use_flags) begin
        res.result_nibble = q[NibW-1:0];
        res.nib_zero      = (q[NibW-1:0] == '0);
        res.nib_carry     = hc;
        res.zero_flag     = !hi && (q[NibW-1:0] == '0) && opnd.peer_zero;
        res.carry_flag    = hi && cf;
        res.overflow_flag = hi && ovf;
      end
    end
  end

endmodule

// File: hw/rtl/nibble_slice_alu_with_flags_top.sv
// Top level of the nibble ALU slice: operand register, ALU core, result register.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  command   | start / busy           | opcode, operand_a, operand_b,
//            |                        | carry_in_global, high_slice,
//            |                        | peer_zero, peer_carry
//  result    | done (one-cycle pulse) | result_nibble, nib_zero, nib_carry,
//            |                        | zero_flag, io_enable_flag, carry_flag,
//            |                        | overflow_flag
//
// A transfer on start gives its result on done after passing through the operand
// register, then through the ALU core into the result register.
// One command per cycle; busy stays low, as nothing in the path can stall.
// Synchronous reset clears the pipeline valid bits; payload registers are not reset.
// The receiver cannot stall: done marks each result for exactly one cycle; the result register holds it until the next.
module nibble_slice_alu_with_flags_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [nsalu_pkg::OpW-1:0]    opcode,
  input  logic [nsalu_pkg::NibW-1:0]   operand_a,
  input  logic [nsalu_pkg::NibW-1:0]   operand_b,
  input  logic                         carry_in_global,
  input  logic                         high_slice,
  input  logic                         peer_zero,
  input  logic                         peer_carry,
  output logic                         done,
  output logic [nsalu_pkg::NibW-1:0]   result_nibble,
  output logic                         nib_zero,
  output logic                         nib_carry,
  output logic                         zero_flag,
  output logic                         io_enable_flag,
  output logic                         carry_flag,
  output logic                         overflow_flag
);
  import nsalu_pkg::*;

  operands_t opnd;
  logic      opnd_valid;
  result_t   alu_res;
  result_t   res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      opnd_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      opnd_valid <= start && !busy;
      done       <= opnd_valid;
    end
  end

  // Load payload only on a transfer; hold otherwise.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      opnd <= '{opcode:          opcode,
                operand_a:       operand_a,
                operand_b:       operand_b,
                carry_in_global: carry_in_global,
                high_slice:      high_slice,
                peer_zero:       peer_zero,
                peer_carry:      peer_carry};
    end
    if (opnd_valid) begin
      res <= alu_res;
    end
  end

  nsalu_core u_core (
    .opnd (opnd),
    .res  (alu_res)
  );

  assign result_nibble  = res.result_nibble;
  assign nib_zero       = res.nib_zero;
  assign nib_carry      = res.nib_carry;
  assign zero_flag      = res.zero_flag;
  assign io_enable_flag = res.io_enable_flag;
  assign carry_flag     = res.carry_flag;
  assign overflow_flag  = res.overflow_flag;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("transfer did not produce a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(opnd_valid))
    else $error("result strobe without a pending operand");

  a_nib_zero: assert property (@(posedge clk) disable iff (rst)
    (done && nib_zero) |-> (result_nibble == '0))
    else $error("nib_zero set on a nonzero nibble");

  a_slice_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !((zero_flag || io_enable_flag) && (carry_flag || overflow_flag)))
    else $error("low-slice and high-slice flags set together");
`endif

endmodule
